/* rtl/core/rgb_to_display_pixel_packer_unit_assert.svh */
// Assertion macros shared by the pixel packer RTL.
`ifndef RGB_TO_DISPLAY_PIXEL_PACKER_UNIT_ASSERT_SVH
`define RGB_TO_DISPLAY_PIXEL_PACKER_UNIT_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define RDPP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RDPP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RDPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/rdpp_pkg.sv */
// Types, codes and helper functions of the RGB to display pixel packer.
`default_nettype none
package rdpp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_RED_MASK   = 3'd0;
  localparam logic [2:0] CFG_GREEN_MASK = 3'd1;
  localparam logic [2:0] CFG_BLUE_MASK  = 3'd2;
  localparam logic [2:0] CFG_PIX_SIZE   = 3'd3;
  localparam logic [2:0] CFG_MSB_FIRST  = 3'd4;
  localparam logic [2:0] CFG_GREY_SRC   = 3'd5;

  // Pixel size modes
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_24 = 2'd2;
  localparam logic [1:0] SIZE_32 = 2'd3;

  localparam logic [31:0] RED_MASK_RST   = 32'h00ff_0000;
  localparam logic [31:0] GREEN_MASK_RST = 32'h0000_ff00;
  localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00ff;

  typedef enum logic [2:0] {
    OP_DITHER,
    OP_GREY32,
    OP_GREY24,
    OP_GREY16,
    OP_PACK32,
    OP_PACK24,
    OP_PACK16
  } op_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       row_start;
  } pix_in_t;

  typedef struct packed {
    logic [31:0] pixel_bytes;
    logic [2:0]  byte_count;
  } pix_out_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_start;
    logic       msb;
  } q_entry_t;

  typedef struct packed {
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
  } cfg_masks_t;

  typedef struct packed {
    logic [2:0] level;
    logic [6:0] err;
  } dith_t;

  // One error diffusion step for one channel.
  function automatic dith_t dither_step(logic [7:0] t, logic [6:0] e);
    logic signed [9:0] d;
    logic signed [9:0] ti;
    logic signed [9:0] sum;
    logic signed [9:0] q;
    logic signed [9:0] nd;
    dith_t res;
    d   = {{3{e[6]}}, e};
    ti  = {2'b00, t};
    sum = ti + d;
    if (sum > 10'sd0 && sum < 10'sd256) begin
      if (d > -10'sd32 && d < 10'sd32) begin
        q = (sum + 10'sd31) & 10'sh1c0;
      end else if (d > 10'sd31) begin
        q = (ti + 10'sd63) & 10'sh1c0;
      end else begin
        q = ti & 10'sh1c0;
      end
    end else if (sum > 10'sd255) begin
      q = 10'sh100;
    end else begin
      q = 10'sd0;
    end
    nd = d + ti - q;
    res.err   = nd[6:0];
    res.level = q[8:6];
    return res;
  endfunction

  // Move an 8-bit channel under its mask: align bit 7 with the top mask bit.
  function automatic logic [31:0] put_field(logic [7:0] v, logic [31:0] mask);
    logic [4:0]  top;
    logic [31:0] wide;
    top = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mask[i]) top = 5'(i);
    end
    wide = {24'b0, v};
    if (top >= 5'd7) begin
      wide = wide << (top - 5'd7);
    end else begin
      wide = wide >> (5'd7 - top);
    end
    return wide & mask;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/rdpp_front.sv */
// Front end: configuration registers and classification of incoming pixels.
`default_nettype none
module rdpp_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire rdpp_pkg::pix_in_t  in_data_i,
  input  wire logic               q_full_i,
  output logic                    in_stall_o,
  output logic                    push_o,
  output rdpp_pkg::q_entry_t      push_data_o,
  output rdpp_pkg::cfg_masks_t    masks_o
);

  logic [31:0] red_bits_q, green_bits_q, blue_bits_q;
  logic [1:0]  size_q;
  logic        msb_q, grey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_bits_q   <= rdpp_pkg::RED_MASK_RST;
      green_bits_q <= rdpp_pkg::GREEN_MASK_RST;
      blue_bits_q  <= rdpp_pkg::BLUE_MASK_RST;
      size_q       <= rdpp_pkg::SIZE_32;
      msb_q        <= 1'b0;
      grey_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rdpp_pkg::CFG_RED_MASK:   red_bits_q   <= cfg_data_i;
        rdpp_pkg::CFG_GREEN_MASK: green_bits_q <= cfg_data_i;
        rdpp_pkg::CFG_BLUE_MASK:  blue_bits_q  <= cfg_data_i;
        rdpp_pkg::CFG_PIX_SIZE:   size_q       <= cfg_data_i[1:0];
        rdpp_pkg::CFG_MSB_FIRST:  msb_q        <= cfg_data_i[0];
        rdpp_pkg::CFG_GREY_SRC:   grey_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign masks_o.red_bits   = red_bits_q;
  assign masks_o.green_bits = green_bits_q;
  assign masks_o.blue_bits  = blue_bits_q;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_data_o.red       = in_data_i.red_in;
    push_data_o.green     = grey_q ? in_data_i.red_in : in_data_i.green_in;
    push_data_o.blue      = grey_q ? in_data_i.red_in : in_data_i.blue_in;
    push_data_o.row_start = in_data_i.row_start;
    push_data_o.msb       = msb_q;
    case (size_q)
      rdpp_pkg::SIZE_8:  push_data_o.op = rdpp_pkg::OP_DITHER;
      rdpp_pkg::SIZE_16: push_data_o.op = grey_q ? rdpp_pkg::OP_GREY16 : rdpp_pkg::OP_PACK16;
      rdpp_pkg::SIZE_24: push_data_o.op = grey_q ? rdpp_pkg::OP_GREY24 : rdpp_pkg::OP_PACK24;
      default:           push_data_o.op = grey_q ? rdpp_pkg::OP_GREY32 : rdpp_pkg::OP_PACK32;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/rdpp_queue.sv */
// Short FIFO of classified pixels between the front and back ends.
`default_nettype none
`include "rgb_to_display_pixel_packer_unit_assert.svh"
module rdpp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire rdpp_pkg::q_entry_t push_data_i,
  input  wire logic               pop_i,
  output logic                    full_o,
  output logic                    valid_o,
  output rdpp_pkg::q_entry_t      head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rdpp_pkg::q_entry_t entries_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];

  `RDPP_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH), "queue overfilled")
  `RDPP_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "queue count lost a push")
  `RDPP_ASSERT_IMPLY(a_empty_ptrs, clk_i, rst_ni, count_q == '0, rd_ptr_q == wr_ptr_q, "empty queue with split pointers")

endmodule
`default_nettype wire

/* rtl/core/rdpp_back.sv */
// Back end: dither state, field packing and the output register.
`default_nettype none
`include "rgb_to_display_pixel_packer_unit_assert.svh"
module rdpp_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  input  wire rdpp_pkg::q_entry_t   head_i,
  input  wire rdpp_pkg::cfg_masks_t masks_i,
  input  wire logic                 out_stall_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  output rdpp_pkg::pix_out_t        out_data_o
);

  logic [6:0] red_err_q, green_err_q, blue_err_q;
  logic [6:0] red_err_d, green_err_d, blue_err_d;
  logic       out_valid_q;
  rdpp_pkg::pix_out_t out_q, out_d;

  logic [6:0]     red_e, green_e, blue_e;
  rdpp_pkg::dith_t dr, dg, db;
  logic [6:0]     idx;
  logic [31:0]    word;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    // row start clears the errors before this pixel uses them
    red_e   = head_i.row_start ? 7'd0 : red_err_q;
    green_e = head_i.row_start ? 7'd0 : green_err_q;
    blue_e  = head_i.row_start ? 7'd0 : blue_err_q;
    dr = rdpp_pkg::dither_step(head_i.red,   red_e);
    dg = rdpp_pkg::dither_step(head_i.green, green_e);
    db = rdpp_pkg::dither_step(head_i.blue,  blue_e);
    idx = ({4'b0, dr.level} * 7'd25) + ({4'b0, dg.level} * 7'd5) + {4'b0, db.level};
    word = rdpp_pkg::put_field(head_i.red,   masks_i.red_bits)
         | rdpp_pkg::put_field(head_i.green, masks_i.green_bits)
         | rdpp_pkg::put_field(head_i.blue,  masks_i.blue_bits);

    red_err_d   = red_e;
    green_err_d = green_e;
    blue_err_d  = blue_e;

    case (head_i.op)
      rdpp_pkg::OP_DITHER: begin
        red_err_d   = dr.err;
        green_err_d = dg.err;
        blue_err_d  = db.err;
        out_d.pixel_bytes = {25'b0, idx};
        out_d.byte_count  = 3'd1;
      end
      rdpp_pkg::OP_GREY32: begin
        out_d.pixel_bytes = head_i.msb ? {head_i.red, head_i.red, head_i.red, 8'b0}
                                       : {8'b0, head_i.red, head_i.red, head_i.red};
        out_d.byte_count  = 3'd4;
      end
      rdpp_pkg::OP_GREY24: begin
        out_d.pixel_bytes = {8'b0, head_i.red, head_i.red, head_i.red};
        out_d.byte_count  = 3'd3;
      end
      rdpp_pkg::OP_GREY16: begin
        // fixed 565 layout, always low byte first
        out_d.pixel_bytes = {16'b0, head_i.red[7:3], head_i.red[7:2], head_i.red[7:3]};
        out_d.byte_count  = 3'd2;
      end
      rdpp_pkg::OP_PACK32: begin
        out_d.pixel_bytes = head_i.msb ? {word[7:0], word[15:8], word[23:16], word[31:24]}
                                       : word;
        out_d.byte_count  = 3'd4;
      end
      rdpp_pkg::OP_PACK24: begin
        out_d.pixel_bytes = head_i.msb ? {8'b0, word[7:0], word[15:8], word[23:16]}
                                       : {8'b0, word[23:0]};
        out_d.byte_count  = 3'd3;
      end
      rdpp_pkg::OP_PACK16: begin
        out_d.pixel_bytes = head_i.msb ? {16'b0, word[7:0], word[15:8]}
                                       : {16'b0, word[15:0]};
        out_d.byte_count  = 3'd2;
      end
      default: begin
        out_d.pixel_bytes = 32'b0;
        out_d.byte_count  = 3'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_err_q   <= 7'd0;
      green_err_q <= 7'd0;
      blue_err_q  <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        red_err_q   <= red_err_d;
        green_err_q <= green_err_d;
        blue_err_q  <= blue_err_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the payload while stalled
  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RDPP_ASSERT_IMPLY(a_count_range, clk_i, rst_ni, out_valid_q, out_q.byte_count != 3'd0 && out_q.byte_count <= 3'd4, "bad byte count")
  `RDPP_ASSERT_NEXT(a_pop_fills, clk_i, rst_ni, pop_o, out_valid_q, "popped transaction not registered")
  `RDPP_ASSERT_ALWAYS(a_err_bound, clk_i, rst_ni, !(red_err_q[6] && !red_err_q[5]) && !(!red_err_q[6] && red_err_q[5] && (red_err_q[4:0] != 5'd0)), "red dither error out of range")

endmodule
`default_nettype wire

/* rtl/core/rgb_to_display_pixel_packer_unit.sv */
// Top level of the RGB to display pixel packer.
`default_nettype none
// Converts one 8-bit RGB or grey pixel per transaction into display pixel
// bytes (32, 24 or 16 bpp through the field masks, or an 8 bpp palette index
// with per-row error diffusion). Throughput is one pixel per clock while the
// output does not stall; an accepted pixel is written into the FIFO, moves to
// the output register when the back end pops it, then leaves unless stalled.
// The front end classifies pixels into a QUEUE_DEPTH-entry FIFO, so input
// keeps flowing for that many pixels while the output stalls. The dither
// error registers are updated as each pixel leaves the FIFO, which sets the
// one-per-clock figure. Program registers only while the block is idle.
module rgb_to_display_pixel_packer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rdpp_pkg::pix_in_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rdpp_pkg::pix_out_t     out_data_o
);

  logic                 q_full, q_valid, push, pop;
  rdpp_pkg::q_entry_t   push_data, head;
  rdpp_pkg::cfg_masks_t masks;

  rdpp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_data_o (push_data),
    .masks_o     (masks)
  );

  rdpp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  rdpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .masks_i     (masks),
    .out_stall_i (out_stall_i),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the RGB to display pixel packer.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int LONG_HOLD       = 300;
  localparam int NUM_PHASES      = 16;
  localparam int ITEMS_PER_PHASE = 125;

  localparam int QUANT_MASK = 'h1c0;
  localparam int QUANT_FULL = 'h100;

  typedef struct packed {
    logic [2:0] level;
    logic [6:0] err;
  } quant_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [2:0]           cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  rdpp_pkg::pix_in_t    in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  rdpp_pkg::pix_out_t   out_data_o;

  // Shadow of the programmed registers and the per-row dither errors
  logic [31:0] red_bits_q = rdpp_pkg::RED_MASK_RST;
  logic [31:0] green_bits_q = rdpp_pkg::GREEN_MASK_RST;
  logic [31:0] blue_bits_q = rdpp_pkg::BLUE_MASK_RST;
  logic [1:0]  pix_size_q = rdpp_pkg::SIZE_32;
  logic        msb_first_q = 1'b0;
  logic        grey_src_q = 1'b0;
  logic [6:0]  red_err_q = '0;
  logic [6:0]  green_err_q = '0;
  logic [6:0]  blue_err_q = '0;

  rdpp_pkg::pix_in_t  pixel_queue[$];
  rdpp_pkg::pix_out_t expected_pixels[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  rgb_to_display_pixel_packer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] place_channel(logic [7:0] v, logic [31:0] mask);
    int top;
    int s;
    top = -1;
    for (int b = 0; b < 32; b++) begin
      if (mask[b]) top = b;
    end
    s = (top < 0) ? 0 : top - 7;
    if (s >= 0) return ({24'b0, v} << s) & mask;
    return ({24'b0, v} >> (-s)) & mask;
  endfunction

  function automatic quant_t quantize(logic [7:0] t, logic [6:0] err);
    int d;
    int ti;
    int sum;
    int q;
    quant_t res;
    d   = int'($signed(err));
    ti  = int'(t);
    sum = ti + d;
    if (sum > 0 && sum < 256) begin
      if (d > -32 && d < 32) begin
        q = (sum + 31) & QUANT_MASK;
      end else if (d > 31) begin
        q = (ti + 63) & QUANT_MASK;
      end else begin
        q = ti & QUANT_MASK;
      end
    end else if (sum > 255) begin
      q = QUANT_FULL;
    end else begin
      q = 0;
    end
    res.err   = 7'(d + ti - q);
    res.level = 3'(q >> 6);
    return res;
  endfunction

  // Advances the dither state as a side effect.
  function automatic rdpp_pkg::pix_out_t predict_pixel(rdpp_pkg::pix_in_t px);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [31:0] word;
    quant_t      qr;
    quant_t      qg;
    quant_t      qb;
    rdpp_pkg::pix_out_t res;
    r = px.red_in;
    g = px.green_in;
    b = px.blue_in;
    if (px.row_start) begin
      red_err_q   = '0;
      green_err_q = '0;
      blue_err_q  = '0;
    end
    if (grey_src_q) begin
      g = r;
      b = r;
    end
    if (pix_size_q == rdpp_pkg::SIZE_8) begin
      qr = quantize(r, red_err_q);
      qg = quantize(g, green_err_q);
      qb = quantize(b, blue_err_q);
      red_err_q   = qr.err;
      green_err_q = qg.err;
      blue_err_q  = qb.err;
      res.pixel_bytes = 32'(qr.level) * 25 + 32'(qg.level) * 5 + 32'(qb.level);
      res.byte_count  = 3'd1;
    end else if (grey_src_q) begin
      case (pix_size_q)
        rdpp_pkg::SIZE_16: begin
          res.pixel_bytes = {16'h0, r[7:3], r[7:2], r[7:3]};
          res.byte_count  = 3'd2;
        end
        rdpp_pkg::SIZE_24: begin
          res.pixel_bytes = {8'h0, r, r, r};
          res.byte_count  = 3'd3;
        end
        default: begin
          res.pixel_bytes = msb_first_q ? {r, r, r, 8'h0} : {8'h0, r, r, r};
          res.byte_count  = 3'd4;
        end
      endcase
    end else begin
      word = place_channel(r, red_bits_q) | place_channel(g, green_bits_q)
           | place_channel(b, blue_bits_q);
      case (pix_size_q)
        rdpp_pkg::SIZE_16: begin
          res.pixel_bytes = msb_first_q ? {16'h0, word[7:0], word[15:8]}
                                        : {16'h0, word[15:0]};
          res.byte_count  = 3'd2;
        end
        rdpp_pkg::SIZE_24: begin
          res.pixel_bytes = msb_first_q ? {8'h0, word[7:0], word[15:8], word[23:16]}
                                        : {8'h0, word[23:0]};
          res.byte_count  = 3'd3;
        end
        default: begin
          res.pixel_bytes = msb_first_q
                          ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
          res.byte_count  = 3'd4;
        end
      endcase
    end
    return res;
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      rdpp_pkg::CFG_RED_MASK:   red_bits_q   = data;
      rdpp_pkg::CFG_GREEN_MASK: green_bits_q = data;
      rdpp_pkg::CFG_BLUE_MASK:  blue_bits_q  = data;
      rdpp_pkg::CFG_PIX_SIZE:   pix_size_q   = data[1:0];
      rdpp_pkg::CFG_MSB_FIRST:  msb_first_q  = data[0];
      rdpp_pkg::CFG_GREY_SRC:   grey_src_q   = data[0];
      default: ;
    endcase
  endfunction

  // Sender: hold a stalled transaction, otherwise offer the next pixel or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_pixels.push_back(predict_pixel(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pixel_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transaction against the oldest expected pixel
  always @(posedge clk_i) begin : monitor
    rdpp_pkg::pix_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, actual bytes %h count %0d",
                 $time, out_data_o.pixel_bytes, out_data_o.byte_count);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data_o.pixel_bytes !== want.pixel_bytes) begin
          $display("%0t: pixel_bytes mismatch: expected %h actual %h",
                   $time, want.pixel_bytes, out_data_o.pixel_bytes);
          mismatch_count++;
        end
        if (out_data_o.byte_count !== want.byte_count) begin
          $display("%0t: byte_count mismatch: expected %0d actual %0d",
                   $time, want.byte_count, out_data_o.byte_count);
          mismatch_count++;
        end
      end
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_go != hold_seen) begin
      hold_seen   <= hold_go;
      hold_left   <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic put(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic rs);
    rdpp_pkg::pix_in_t px;
    px.red_in    = r;
    px.green_in  = g;
    px.blue_in   = b;
    px.row_start = rs;
    pixel_queue.push_back(px);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pixel_queue.size() != 0 || in_valid_i || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    apply_cfg(idx, data);
  endtask

  task automatic cfg_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Narrow registers get random upper bits, which must be dropped
  task automatic set_config(logic [31:0] rm, logic [31:0] gm, logic [31:0] bm,
                            logic [1:0] size, logic msb, logic grey);
    logic [31:0] junk;
    junk = $urandom();
    cfg_write(rdpp_pkg::CFG_RED_MASK, rm);
    cfg_write(rdpp_pkg::CFG_GREEN_MASK, gm);
    cfg_write(rdpp_pkg::CFG_BLUE_MASK, bm);
    cfg_write(rdpp_pkg::CFG_PIX_SIZE, {junk[31:2], size});
    cfg_write(rdpp_pkg::CFG_MSB_FIRST, {junk[31:1], msb});
    cfg_write(rdpp_pkg::CFG_GREY_SRC, {junk[30:0], grey});
    cfg_done();
  endtask

  function automatic logic [31:0] pick_mask(logic [31:0] dflt);
    int w;
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hff00_0000;
      4: begin
        w = $urandom_range(8, 1);
        return ((32'h1 << w) - 1) << $urandom_range(32 - w, 0);
      end
      5: return $urandom();
      6: return $urandom_range(127, 1);
      default: return dflt;
    endcase
  endfunction

  function automatic logic [7:0] pick_value();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'(128 + $urandom_range(16) - 8);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int p;
    int row_left;
    logic [1:0] size;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset register values
    put(8'h00, 8'h00, 8'h00, 1'b1);
    put(8'hff, 8'hff, 8'hff, 1'b0);
    put(8'h12, 8'h34, 8'h56, 1'b0);
    wait_idle();

    // Writes to indexes past the register list must change nothing
    cfg_write(3'd6, $urandom());
    cfg_write(3'd7, $urandom());
    cfg_done();
    put(8'h80, 8'h01, 8'hfe, 1'b1);
    wait_idle();

    set_config(32'h0000_f800, 32'h0000_07e0, 32'h0000_001f, rdpp_pkg::SIZE_16,
               1'b0, 1'b0);
    put(8'hff, 8'hff, 8'hff, 1'b0);
    put(8'ha5, 8'h5a, 8'hc3, 1'b0);
    wait_idle();
    set_config(32'h0000_f800, 32'h0000_07e0, 32'h0000_001f, rdpp_pkg::SIZE_16,
               1'b1, 1'b0);
    put(8'ha5, 8'h5a, 8'hc3, 1'b0);
    wait_idle();
    set_config(rdpp_pkg::RED_MASK_RST, rdpp_pkg::GREEN_MASK_RST, rdpp_pkg::BLUE_MASK_RST,
               rdpp_pkg::SIZE_24, 1'b1, 1'b0);
    put(8'h11, 8'h22, 8'h33, 1'b0);
    wait_idle();
    // Zero mask, full mask and a mask whose top bit sits below bit 7
    set_config(32'h0, 32'hffff_ffff, 32'h0000_0007, rdpp_pkg::SIZE_32, 1'b1, 1'b0);
    put(8'hff, 8'hff, 8'hff, 1'b0);
    put(8'h9c, 8'h3e, 8'hb1, 1'b0);
    wait_idle();

    // Grey layouts
    set_config(32'h0, 32'h0, 32'h0, rdpp_pkg::SIZE_32, 1'b0, 1'b1);
    put(8'hc7, 8'h00, 8'hff, 1'b0);
    wait_idle();
    set_config(32'h0, 32'h0, 32'h0, rdpp_pkg::SIZE_32, 1'b1, 1'b1);
    put(8'hc7, 8'h00, 8'hff, 1'b0);
    wait_idle();
    set_config(32'h0, 32'h0, 32'h0, rdpp_pkg::SIZE_24, 1'b1, 1'b1);
    put(8'h3b, 8'h00, 8'h00, 1'b0);
    wait_idle();
    set_config(32'h0, 32'h0, 32'h0, rdpp_pkg::SIZE_16, 1'b1, 1'b1);
    put(8'hd6, 8'h12, 8'h34, 1'b0);
    wait_idle();

    // Dither row: saturation both ways and the large positive error branch
    set_config(rdpp_pkg::RED_MASK_RST, rdpp_pkg::GREEN_MASK_RST, rdpp_pkg::BLUE_MASK_RST,
               rdpp_pkg::SIZE_8, 1'b0, 1'b0);
    put(8'd32, 8'd20, 8'hff, 1'b1);
    put(8'd100, 8'd40, 8'hff, 1'b0);
    put(8'h00, 8'h00, 8'hff, 1'b0);
    put(8'hff, 8'hff, 8'h00, 1'b0);
    put(8'd31, 8'd33, 8'd95, 1'b0);
    wait_idle();
    // Errors survive a wide-mode pixel without row_start, not one with it
    set_config(rdpp_pkg::RED_MASK_RST, rdpp_pkg::GREEN_MASK_RST, rdpp_pkg::BLUE_MASK_RST,
               rdpp_pkg::SIZE_32, 1'b0, 1'b0);
    put(8'h40, 8'h40, 8'h40, 1'b0);
    wait_idle();
    set_config(rdpp_pkg::RED_MASK_RST, rdpp_pkg::GREEN_MASK_RST, rdpp_pkg::BLUE_MASK_RST,
               rdpp_pkg::SIZE_8, 1'b0, 1'b1);
    put(8'd150, 8'h00, 8'h00, 1'b0);
    put(8'd70, 8'h00, 8'h00, 1'b0);
    wait_idle();
    set_config(rdpp_pkg::RED_MASK_RST, rdpp_pkg::GREEN_MASK_RST, rdpp_pkg::BLUE_MASK_RST,
               rdpp_pkg::SIZE_24, 1'b0, 1'b0);
    put(8'h40, 8'h40, 8'h40, 1'b1);
    wait_idle();
    set_config(rdpp_pkg::RED_MASK_RST, rdpp_pkg::GREEN_MASK_RST, rdpp_pkg::BLUE_MASK_RST,
               rdpp_pkg::SIZE_8, 1'b0, 1'b0);
    put(8'd70, 8'd70, 8'd70, 1'b0);
    wait_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      size = 2'((p + p / 4) % 4);
      set_config(pick_mask(rdpp_pkg::RED_MASK_RST), pick_mask(rdpp_pkg::GREEN_MASK_RST),
                 pick_mask(rdpp_pkg::BLUE_MASK_RST), size, 1'($urandom_range(1)),
                 1'($urandom_range(3) == 0));
      // Stall the output long enough to back the block up into its input
      if (p == 4) begin
        @(posedge clk_i);
        hold_go <= ~hold_go;
        @(negedge clk_i);
      end
      row_left = 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 5 && i == ITEMS_PER_PHASE / 2) wait_idle();
        if (row_left == 0) begin
          row_left = $urandom_range(40, 1);
          put(pick_value(), pick_value(), pick_value(), 1'b1);
        end else begin
          put(pick_value(), pick_value(), pick_value(), $urandom_range(19) == 0);
        end
        row_left--;
      end
      wait_idle();
    end

    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d expected pixels never arrived", $time, expected_pixels.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
